### rtl/lsph_pkg.sv
// Package for the lattice-site linear-probe hash set.
// Holds operation codes, status codes, state and queue types and the home-slot hash.
// Depends on nothing.
package lsph_pkg;

  localparam int TableDepthDef = 4096;
  localparam int MaxMonomersDef = 1024;
  localparam int CoordW = 11;
  localparam int SiteW = 3 * CoordW;
  localparam int MonoW = 10;
  localparam int SlotW = 12;
  localparam int HashW = 28;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MSLOT,
    S_RDHOME,
    S_PROBE,
    S_RMREAD,
    S_RMCHK,
    S_SCAN,
    S_RIPROBE,
    S_CLRSWEEP
  } bstate_t;

  // One queued command word, with the partial hash sum already formed.
  typedef struct packed {
    op_t                op;
    logic [SiteW-1:0]   site;
    logic [MonoW-1:0]   monomer;
    logic [HashW-1:0]   absum;
  } cmd_t;

  // Absolute value of 17x + 290y + 4914z.
  function automatic logic [HashW-1:0] hash_abs(input logic [SiteW-1:0] site);
    logic signed [HashW:0] x, y, z, s;
    x = (HashW+1)'(signed'(site[CoordW-1:0]));
    y = (HashW+1)'(signed'(site[2*CoordW-1:CoordW]));
    z = (HashW+1)'(signed'(site[3*CoordW-1:2*CoordW]));
    s = (HashW+1)'(17 * x + 290 * y + 4914 * z);
    if (s < 0) begin
      s = -s;
    end
    return s[HashW-1:0];
  endfunction

endpackage

### rtl/lsph_front.sv
// Front end: accepts command words, forms the hash sum and queues the words.
// Depends on lsph_pkg.
module lsph_front
  import lsph_pkg::*;
#(
  parameter int QDepth = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] op,
  input  logic signed [CoordW-1:0] key_x,
  input  logic signed [CoordW-1:0] key_y,
  input  logic signed [CoordW-1:0] key_z,
  input  logic [MonoW-1:0] monomer,
  output logic busy,
  output logic q_valid,
  output cmd_t q_word,
  input  logic q_pop
);

  localparam int PW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;
  logic            push;
  cmd_t            in_word;

  // Build the word; the hash sum is formed here so the back end only folds it.
  always_comb begin
    in_word.op = op_t'(op);
    in_word.site = {key_z, key_y, key_x};
    in_word.monomer = monomer;
    in_word.absum = hash_abs({key_z, key_y, key_x});
  end

  assign busy = (count == (PW+1)'(QDepth));
  assign push = start && !busy;
  assign q_valid = (count != '0);
  assign q_word = q_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_word;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDepth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDepth-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QDepth)) else $error("queue overfilled");
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    (busy && !q_pop) |=> busy) else $error("full queue drained without pop");

endmodule

### rtl/lsph_back.sv
// Back end: carries out lookup, insert, remove with rehash and clear on the table memories.
// Depends on lsph_pkg.
module lsph_back
  import lsph_pkg::*;
#(
  parameter int TableDepth = TableDepthDef,
  parameter int MaxMonomers = MaxMonomersDef
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_word,
  output logic q_pop,
  output logic done,
  output logic found,
  output logic [SlotW-1:0] slot,
  output logic [1:0] status
);

  localparam int AW = $clog2(TableDepth);
  localparam int MW = $clog2(MaxMonomers);

  // Memories: used bits, site and owner per slot; recorded slot per monomer.
  logic               used_mem  [TableDepth];
  logic [SiteW-1:0]   site_mem  [TableDepth];
  logic [MonoW-1:0]   owner_mem [TableDepth];
  logic [AW-1:0]      mslot_mem [MaxMonomers];

  bstate_t state, state_next;
  cmd_t    cmd;
  logic [AW-1:0] addr, addr_next;
  logic [AW:0]   cnt, cnt_next;
  logic [AW-1:0] scan, scan_next;
  logic [AW:0]   scnt, scnt_next;
  logic [SiteW-1:0] ri_site;
  logic [MonoW-1:0] ri_owner;
  logic          ri_load;
  logic          rd_used;
  logic [SiteW-1:0] rd_site;
  logic [MonoW-1:0] rd_owner;
  logic [AW-1:0] rd_mslot;
  logic [AW-1:0] rd_addr;
  logic          we_used, used_val;
  logic [AW-1:0] we_addr;
  logic          we_entry, we_mslot;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          load;
  logic          r_done, r_found;
  logic [AW-1:0] r_slot;
  status_t       r_status;
  logic [SiteW-1:0] cur_site;
  logic [MonoW-1:0] cur_owner;
  logic          mono_ok;

  assign mono_ok = (32'(cmd.monomer) < 32'(MaxMonomers));
  assign cur_site = (state == S_RIPROBE) ? ri_site : cmd.site;
  assign cur_owner = (state == S_RIPROBE) ? ri_owner : cmd.monomer;

  // Registered memory reads; a write to the same slot in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    rd_used  <= (we_used && we_addr == rd_addr) ? used_val : used_mem[rd_addr];
    rd_site  <= (we_entry && we_addr == rd_addr) ? cur_site : site_mem[rd_addr];
    rd_owner <= (we_entry && we_addr == rd_addr) ? cur_owner : owner_mem[rd_addr];
    rd_mslot <= mslot_mem[MW'(cmd.monomer)];
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (we_used) begin
      used_mem[we_addr] <= used_val;
    end
    if (we_entry) begin
      site_mem[we_addr] <= cur_site;
      owner_mem[we_addr] <= cur_owner;
    end
    if (we_mslot) begin
      mslot_mem[MW'(cur_owner)] <= we_addr;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLRSWEEP;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      done <= r_done;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr <= addr_next;
    cnt <= cnt_next;
    scan <= scan_next;
    scnt <= scnt_next;
    found <= r_found;
    slot <= SlotW'(r_slot);
    status <= r_status;
    if (load) begin
      cmd <= q_word;
    end
    if (ri_load) begin
      ri_site <= rd_site;
      ri_owner <= rd_owner;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    addr_next = addr;
    cnt_next = cnt;
    scan_next = scan;
    scnt_next = scnt;
    clr_addr_next = clr_addr;
    rd_addr = addr;
    we_used = 1'b0;
    used_val = 1'b0;
    we_addr = addr;
    we_entry = 1'b0;
    we_mslot = 1'b0;
    load = 1'b0;
    q_pop = 1'b0;
    ri_load = 1'b0;
    r_done = 1'b0;
    r_found = 1'b0;
    r_slot = '0;
    r_status = ST_OK;
    case (state)
      S_CLRSWEEP: begin
        we_used = 1'b1;
        we_addr = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(TableDepth-1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          load = 1'b1;
          q_pop = 1'b1;
          state_next = (q_word.op == OP_LOOKUP || q_word.op == OP_INSERT) ? S_RDHOME : S_MSLOT;
        end
      end
      S_MSLOT: begin
        // Recorded slot is read this cycle.
        if (!mono_ok) begin
          r_done = 1'b1;
          r_status = (cmd.op == OP_REMOVE) ? ST_EMPTY : ST_OK;
          state_next = S_IDLE;
        end else begin
          state_next = S_RMREAD;
        end
      end
      S_RMREAD: begin
        addr_next = rd_mslot;
        rd_addr = rd_mslot;
        if (cmd.op == OP_CLEAR) begin
          we_used = 1'b1;
          we_addr = rd_mslot;
          r_done = 1'b1;
          r_slot = rd_mslot;
          state_next = S_IDLE;
        end else begin
          state_next = S_RMCHK;
        end
      end
      S_RMCHK: begin
        if (!rd_used) begin
          r_done = 1'b1;
          r_slot = addr;
          r_status = ST_EMPTY;
          state_next = S_IDLE;
        end else begin
          we_used = 1'b1;
          r_done = 1'b1;
          r_slot = addr;
          scan_next = addr + 1'b1;
          rd_addr = addr + 1'b1;
          scnt_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // rd_* holds the slot at scan.
        if (!rd_used || scnt == (AW+1)'(TableDepth)) begin
          state_next = S_IDLE;
        end else begin
          // Free the slot and start probing from the entry's home.
          we_used = 1'b1;
          we_addr = scan;
          ri_load = 1'b1;
          cnt_next = '0;
          addr_next = AW'(hash_abs(rd_site));
          rd_addr = AW'(hash_abs(rd_site));
          scnt_next = scnt + 1'b1;
          state_next = S_RIPROBE;
        end
      end
      S_RDHOME: begin
        addr_next = AW'(cmd.absum);
        rd_addr = AW'(cmd.absum);
        cnt_next = '0;
        state_next = S_PROBE;
      end
      S_PROBE, S_RIPROBE: begin
        // The slot freed by the scan step reads as empty through the read forwarding.
        if (cnt == (AW+1)'(TableDepth)) begin
          if (state == S_PROBE) begin
            r_done = 1'b1;
            r_status = (cmd.op == OP_INSERT) ? ST_FULL : ST_OK;
            state_next = S_IDLE;
          end else begin
            state_next = S_SCAN;
            rd_addr = scan + 1'b1;
            scan_next = scan + 1'b1;
          end
        end else if (!rd_used) begin
          if (state == S_PROBE) begin
            r_done = 1'b1;
            if (cmd.op == OP_INSERT) begin
              we_used = 1'b1;
              used_val = 1'b1;
              we_entry = 1'b1;
              we_mslot = mono_ok;
              r_slot = addr;
            end
            state_next = S_IDLE;
          end else begin
            we_used = 1'b1;
            used_val = 1'b1;
            we_entry = 1'b1;
            we_mslot = (32'(ri_owner) < 32'(MaxMonomers));
            state_next = S_SCAN;
            rd_addr = scan + 1'b1;
            scan_next = scan + 1'b1;
          end
        end else if (rd_site == cur_site) begin
          if (state == S_PROBE) begin
            r_done = 1'b1;
            r_found = 1'b1;
            r_slot = addr;
            state_next = S_IDLE;
          end else begin
            state_next = S_SCAN;
            rd_addr = scan + 1'b1;
            scan_next = scan + 1'b1;
          end
        end else begin
          addr_next = addr + 1'b1;
          rd_addr = addr + 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop outside idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for two cycles");
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    done |-> status != ST_UNUSED) else $error("bad status");

endmodule

### rtl/lattice_site_linear_probe_hash.sv
// Lattice-site linear-probe hash set, top level.
// Usage: raise start with op, key_x, key_y, key_z and monomer; the word is
// taken at an edge where start is high and busy is low. busy is high only
// while the two-word command queue is full.
// Each word gives exactly one result on found, slot and status, marked by a
// one-cycle done strobe; the receiver cannot hold results off.
// Steps of each word in the back end: lookup and insert read the home slot and
// then probe slot by slot; clear reads the monomer's recorded slot and frees it;
// remove reads the recorded slot and checks it, gives its result, then the back end
// keeps rehashing the cluster, a scan step plus a probe step per probed slot for each
// entry and a closing scan step.
// The back end serves one word at a time and takes no new word until all steps of
// the last word, for a remove the rehash too, are done.
// After reset the back end sweeps the used bits of every slot, during
// which words are queued but not served (busy rises once the queue fills).
// Depends on lsph_pkg, lsph_front and lsph_back.
module lattice_site_linear_probe_hash
  import lsph_pkg::*;
#(
  parameter int TableDepth = TableDepthDef,
  parameter int MaxMonomers = MaxMonomersDef
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] op,
  input  logic signed [CoordW-1:0] key_x,
  input  logic signed [CoordW-1:0] key_y,
  input  logic signed [CoordW-1:0] key_z,
  input  logic [MonoW-1:0] monomer,
  output logic done,
  output logic found,
  output logic [SlotW-1:0] slot,
  output logic [1:0] status
);

  logic q_valid, q_pop;
  cmd_t q_word;

  lsph_front u_front (
    .clk, .rst, .start, .op, .key_x, .key_y, .key_z, .monomer,
    .busy, .q_valid, .q_word, .q_pop
  );

  lsph_back #(.TableDepth(TableDepth), .MaxMonomers(MaxMonomers)) u_back (
    .clk, .rst, .q_valid, .q_word, .q_pop, .done, .found, .slot, .status
  );

endmodule

### bench/tb_lattice_site_linear_probe_hash.sv
// Self-checking testbench for the lattice-site linear-probe hash set.
// Runs a directed table, four random phases and a wrapped-cluster phase against a predictor.
// Depends on lsph_pkg and lattice_site_linear_probe_hash.
module tb_lattice_site_linear_probe_hash;
  import lsph_pkg::*;

  localparam int Depth = 4096;
  localparam int Monos = 1024;
  localparam int StallLimit = 200000;
  localparam int PoolSize = 48;

  typedef struct {
    logic             found;
    logic [SlotW-1:0] slot;
    status_t          status;
  } answer_t;

  typedef struct {
    op_t              o;
    int               x, y, z;
    int               m;
    bit               lit;
    logic             found;
    logic [SlotW-1:0] slot;
    status_t          status;
  } row_t;

  typedef enum int {PR_HIT, PR_EMPTY, PR_FULL} probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = '0;
  logic signed [CoordW-1:0] key_x = '0;
  logic signed [CoordW-1:0] key_y = '0;
  logic signed [CoordW-1:0] key_z = '0;
  logic [MonoW-1:0] monomer = '0;
  logic busy, done, found;
  logic [SlotW-1:0] slot;
  logic [1:0] status;

  // Shadow copy of the table contents.
  bit               occupied [Depth];
  logic [SiteW-1:0] site_at  [Depth];
  logic [MonoW-1:0] owner_at [Depth];
  logic [SlotW-1:0] home_slot_of [Monos];
  bit               placed   [Monos];
  int               occupied_count;

  logic [SiteW-1:0] cluster_pool [PoolSize];
  answer_t pending_answers [$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  int empty_removes = 0;

  lattice_site_linear_probe_hash dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Home slot: absolute weighted coordinate sum, modulo the depth.
  function automatic int home_slot(logic [SiteW-1:0] s);
    longint sum;
    sum = 17 * longint'($signed(s[10:0])) + 290 * longint'($signed(s[21:11]))
        + 4914 * longint'($signed(s[32:22]));
    if (sum < 0) begin
      sum = -sum;
    end
    return int'(sum % Depth);
  endfunction

  function automatic probe_t probe_site(logic [SiteW-1:0] s, output int where);
    int p;
    p = home_slot(s);
    for (int k = 0; k < Depth; k++) begin
      if (!occupied[p]) begin
        where = p;
        return PR_EMPTY;
      end
      if (site_at[p] == s) begin
        where = p;
        return PR_HIT;
      end
      p = (p + 1) % Depth;
    end
    where = 0;
    return PR_FULL;
  endfunction

  function automatic probe_t place_site(logic [SiteW-1:0] s, logic [MonoW-1:0] m,
                                        output int where);
    probe_t r;
    r = probe_site(s, where);
    if (r == PR_EMPTY) begin
      occupied[where] = 1'b1;
      occupied_count++;
      site_at[where] = s;
      owner_at[where] = m;
      home_slot_of[m] = SlotW'(where);
      placed[m] = 1'b1;
    end
    return r;
  endfunction

  // Predicts one word's answer and updates the shadow table.
  function automatic answer_t hash_set_answer(op_t o, logic [SiteW-1:0] s,
                                              logic [MonoW-1:0] m);
    answer_t a;
    probe_t r;
    int where, addr, i;
    a = '{1'b0, '0, ST_OK};
    case (o)
      OP_LOOKUP: begin
        if (probe_site(s, where) == PR_HIT) begin
          a.found = 1'b1;
          a.slot = SlotW'(where);
        end
      end
      OP_INSERT: begin
        r = place_site(s, m, where);
        if (r == PR_FULL) begin
          a.status = ST_FULL;
        end else begin
          a.found = (r == PR_HIT);
          a.slot = SlotW'(where);
        end
      end
      OP_REMOVE: begin
        addr = int'(home_slot_of[m]);
        a.slot = SlotW'(addr);
        if (!occupied[addr]) begin
          a.status = ST_EMPTY;
        end else begin
          occupied[addr] = 1'b0;
          occupied_count--;
          i = addr;
          // Pull each following entry out and place it again.
          for (int k = 0; k < Depth; k++) begin
            i = (i + 1) % Depth;
            if (!occupied[i]) begin
              break;
            end
            occupied[i] = 1'b0;
            occupied_count--;
            void'(place_site(site_at[i], owner_at[i], where));
          end
        end
      end
      default: begin
        addr = int'(home_slot_of[m]);
        if (occupied[addr]) begin
          occupied_count--;
        end
        occupied[addr] = 1'b0;
        a.slot = SlotW'(addr);
      end
    endcase
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Sends one command word and queues its expected answer.
  task automatic send_word(op_t o, logic [SiteW-1:0] s, logic [MonoW-1:0] m, bit lit,
                           answer_t typed);
    answer_t a;
    a = hash_set_answer(o, s, m);
    if (o == OP_REMOVE && a.status == ST_EMPTY) begin
      empty_removes++;
    end
    pending_answers.push_back(lit ? typed : a);
    start <= 1'b1;
    op <= o;
    key_x <= s[10:0];
    key_y <= s[21:11];
    key_z <= s[32:22];
    monomer <= m;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    words_sent++;
    // Each idle cycle is followed by another with the phase's idle odds.
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) begin
        @(posedge clk);
      end
    end
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [SiteW-1:0] random_site();
    if ($urandom_range(99) < 65) begin
      return cluster_pool[$urandom_range(PoolSize - 1)];
    end
    return SiteW'({$urandom, $urandom});
  endfunction

  // Compare each result against the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("MISMATCH: result %0d arrived with nothing expected", results_seen);
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found) report("found", found, want.found);
        if (slot !== want.slot) report("slot", slot, want.slot);
        if (status !== want.status) report("status", status, want.status);
      end
    end
  end

  // Watchdog on cycles with no accepted word and no result.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Watchdog expired with %0d results outstanding", pending_answers.size());
      $display("lattice_site_linear_probe_hash verification failed");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    answer_t typed;
    logic [SiteW-1:0] s;
    logic [MonoW-1:0] m;
    op_t o;
    int pick, n, tries;
    logic [SiteW-1:0] wrap_sites [4];
    int phase_idle [4] = '{0, 85, 0, 26};

    occupied_count = 0;
    foreach (occupied[i]) occupied[i] = 1'b0;
    foreach (placed[i]) placed[i] = 1'b0;
    // Sites whose home slots fall in a narrow window, so clusters form.
    n = 0;
    while (n < PoolSize) begin
      s = SiteW'({$urandom, $urandom});
      if (home_slot(s) < 16) begin
        cluster_pool[n] = s;
        n++;
      end
    end

    // Directed rows: extremes, collisions, rehash, clears and empty removes.
    rows = '{
      '{OP_LOOKUP, 0, 0, 0, 0, 1, 1'b0, 12'd0, ST_OK},
      '{OP_INSERT, 0, 0, 0, 0, 1, 1'b0, 12'd0, ST_OK},
      '{OP_INSERT, 0, 0, 0, 1, 1, 1'b1, 12'd0, ST_OK},
      '{OP_LOOKUP, 0, 0, 0, 7, 1, 1'b1, 12'd0, ST_OK},
      '{OP_INSERT, 1023, 1023, 1023, 1023, 0, 1'b0, 12'd0, ST_OK},
      '{OP_INSERT, -1024, -1024, -1024, 512, 0, 1'b0, 12'd0, ST_OK},
      '{OP_INSERT, -1, -1, -1, 5, 0, 1'b0, 12'd0, ST_OK},
      '{OP_INSERT, 1, 0, 0, 2, 1, 1'b0, 12'd17, ST_OK},
      '{OP_INSERT, -1, 0, 0, 3, 1, 1'b0, 12'd18, ST_OK},
      '{OP_LOOKUP, -1, 0, 0, 0, 1, 1'b1, 12'd18, ST_OK},
      '{OP_REMOVE, 0, 0, 0, 2, 1, 1'b0, 12'd17, ST_OK},
      '{OP_LOOKUP, -1, 0, 0, 0, 1, 1'b1, 12'd17, ST_OK},
      '{OP_CLEAR, 0, 0, 0, 2, 1, 1'b0, 12'd17, ST_OK},
      '{OP_REMOVE, 0, 0, 0, 2, 1, 1'b0, 12'd17, ST_EMPTY},
      '{OP_CLEAR, 0, 0, 0, 2, 1, 1'b0, 12'd17, ST_OK},
      '{OP_LOOKUP, -1, 0, 0, 0, 1, 1'b0, 12'd0, ST_OK},
      '{OP_REMOVE, 0, 0, 0, 1023, 0, 1'b0, 12'd0, ST_OK},
      '{OP_INSERT, 1023, -1024, 0, 1000, 0, 1'b0, 12'd0, ST_OK},
      '{OP_LOOKUP, -1024, -1024, -1024, 0, 0, 1'b0, 12'd0, ST_OK}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      typed = '{rows[i].found, rows[i].slot, rows[i].status};
      s = {11'(rows[i].z), 11'(rows[i].y), 11'(rows[i].x)};
      send_word(rows[i].o, s, MonoW'(rows[i].m), rows[i].lit, typed);
    end
    drain_answers();

    // Random phases; each sets the sender's idle odds from phase_idle.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int k = 0; k < 260; k++) begin
        pick = $urandom_range(99);
        o = pick < 25 ? OP_LOOKUP : pick < 65 ? OP_INSERT : pick < 85 ? OP_REMOVE : OP_CLEAR;
        m = MonoW'($urandom);
        if (o == OP_REMOVE || o == OP_CLEAR) begin
          // Only monomers with a recorded slot may be removed or cleared.
          tries = 0;
          while (!placed[m] && tries < 64) begin
            m = MonoW'($urandom);
            tries++;
          end
          if (!placed[m]) begin
            o = OP_INSERT;
          end
        end
        send_word(o, random_site(), m, 1'b0, typed);
      end
      drain_answers();
    end

    // Sites homed in the last two slots, so their cluster wraps past slot 0.
    idle_pct = 0;
    n = 0;
    while (n < 4) begin
      s = SiteW'({$urandom, $urandom});
      if (home_slot(s) >= Depth - 2) begin
        wrap_sites[n] = s;
        n++;
      end
    end
    foreach (wrap_sites[i]) begin
      send_word(OP_INSERT, wrap_sites[i], MonoW'(1001 + i), 1'b0, typed);
    end
    if (placed[1001]) begin
      send_word(OP_REMOVE, wrap_sites[0], 10'd1001, 1'b0, typed);
    end
    if (placed[1002]) begin
      send_word(OP_CLEAR, wrap_sites[1], 10'd1002, 1'b0, typed);
    end
    foreach (wrap_sites[i]) begin
      send_word(OP_LOOKUP, wrap_sites[i], 10'd0, 1'b0, typed);
    end
    drain_answers();
    repeat (50) @(posedge clk);

    $display("Sent %0d words and checked %0d results over directed rows, gapped random",
             words_sent, results_seen);
    $display("phases and a cluster wrapping the table end; %0d removes of empty slots.",
             empty_removes);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("lattice_site_linear_probe_hash verification clean");
    end else begin
      $display("lattice_site_linear_probe_hash verification failed");
    end
    $finish;
  end

endmodule
